// ----- rtl/gmw_pkg.sv -----
// shared types, constants and helpers for the grid maze wall follower
// no dependencies; used by the interfaces and every module
`default_nettype none

package gmw_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int ROW_W    = 6;
	localparam int COL_W    = 6;
	localparam int ADDR_W   = ROW_W + COL_W;
	localparam int DEPTH    = MAX_ROWS * MAX_COLS;
	localparam int DIM_W    = 7;

	localparam logic [DIM_W-1:0] MAX_ROWS_DIM = DIM_W'(MAX_ROWS);
	localparam logic [DIM_W-1:0] MAX_COLS_DIM = DIM_W'(MAX_COLS);

	// configuration register indexes
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	// item modes
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_STEP  = 2'd2;

	// cell kinds
	localparam logic [1:0] KIND_OPEN  = 2'd0;
	localparam logic [1:0] KIND_WALL  = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;
	localparam logic [1:0] KIND_EXIT  = 2'd3;

	// headings
	localparam logic [1:0] DIR_N = 2'd0;
	localparam logic [1:0] DIR_E = 2'd1;
	localparam logic [1:0] DIR_S = 2'd2;
	localparam logic [1:0] DIR_W = 2'd3;

	// result status codes
	localparam logic [3:0] ST_WRITTEN  = 4'd0;
	localparam logic [3:0] ST_STARTED  = 4'd1;
	localparam logic [3:0] ST_BAD_EDGE = 4'd2;
	localparam logic [3:0] ST_BAD_CNT  = 4'd3;
	localparam logic [3:0] ST_MOVED    = 4'd4;
	localparam logic [3:0] ST_EXIT     = 4'd5;
	localparam logic [3:0] ST_BACK     = 4'd6;
	localparam logic [3:0] ST_BLOCKED  = 4'd7;
	localparam logic [3:0] ST_INACTIVE = 4'd8;

	localparam logic [1:0] LAST_TRY = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_END,
		S_SCAN_DONE,
		S_STEP_TRY,
		S_STEP_CHK,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [1:0]        wdata;
	} mem_req_t;

	typedef struct packed {
		logic [3:0]       status;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [1:0]       dir;
	} result_t;

	// right, forward, left, back relative to the heading
	function automatic logic [1:0] try_dir(input logic [1:0] heading, input logic [1:0] k);
		logic [1:0] d;
		case (k)
			2'd0:    d = heading + 2'd1;
			2'd1:    d = heading;
			2'd2:    d = heading + 2'd3;
			default: d = heading + 2'd2;
		endcase
		return d;
	endfunction

	// register value limited to 1..max
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] max_v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > max_v) begin
			r = max_v;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/gmw_if.sv -----
// valid/ready channel interfaces for command items and result items
// depends on gmw_pkg for field widths
`default_nettype none

interface gmw_in_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                mode;
	logic [gmw_pkg::ROW_W-1:0] cell_row;
	logic [gmw_pkg::COL_W-1:0] cell_col;
	logic [1:0]                cell_kind;

	modport source (output valid, mode, cell_row, cell_col, cell_kind, input ready);
	modport sink (input valid, mode, cell_row, cell_col, cell_kind, output ready);
endinterface

interface gmw_out_if;
	logic                      valid;
	logic                      ready;
	logic [3:0]                status;
	logic [gmw_pkg::ROW_W-1:0] walker_row;
	logic [gmw_pkg::COL_W-1:0] walker_col;
	logic [1:0]                walker_dir;

	modport source (output valid, status, walker_row, walker_col, walker_dir, input ready);
	modport sink (input valid, status, walker_row, walker_col, walker_dir, output ready);
endinterface

`default_nettype wire

// ----- rtl/gmw_grid_mem.sv -----
// grid cell store: one port, synchronous (registered) read
// depends on gmw_pkg for the request struct and depth
`default_nettype none

module gmw_grid_mem (
	input  wire logic              clk,
	input  wire gmw_pkg::mem_req_t req,
	output logic [1:0]             rdata
);

	logic [1:0] mem [gmw_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/gmw_ctrl.sv -----
// sequencer: cell writes, start scan over the grid, wall-following steps
// depends on gmw_pkg, gmw_if and the grid memory read data
`default_nettype none

module gmw_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	gmw_in_if.sink                          in_ch,
	input  wire logic [gmw_pkg::DIM_W-1:0]  rows_used,
	input  wire logic [gmw_pkg::DIM_W-1:0]  cols_used,
	output gmw_pkg::mem_req_t               mem_req,
	input  wire logic [1:0]                 mem_rdata,
	output logic                            res_valid,
	input  wire logic                       res_ready,
	output gmw_pkg::result_t                res
);

	localparam int RW = gmw_pkg::ROW_W;
	localparam int CW = gmw_pkg::COL_W;
	localparam int DW = gmw_pkg::DIM_W;

	gmw_pkg::state_t state_q, state_d;

	logic [RW-1:0] pos_row_q, origin_row_q, goal_row_q;
	logic [CW-1:0] pos_col_q, origin_col_q, goal_col_q;
	logic [1:0]    heading_q;
	logic          walking_q;
	logic [3:0]    status_q;

	// scan state
	logic [RW-1:0] scan_row_q, row_s1, sr_q, er_q;
	logic [CW-1:0] scan_col_q, col_s1, sc_q, ec_q;
	logic          valid_s1, edge_s1, bad_q;
	logic [1:0]    nstart_q, nexit_q;

	// step state
	logic [1:0]    try_q, cand_dir_s1;
	logic [RW-1:0] cand_row_s1;
	logic [CW-1:0] cand_col_s1;

	logic          accept;
	logic          scan_last, scan_edge;
	logic [DW-1:0] rows_m1, cols_m1;
	logic [1:0]    try_d;
	logic [DW-1:0] nr, nc;
	logic          inb;
	logic          passable;

	function automatic logic mem_mem_kind_is(input logic [1:0] kind);
		return mem_rdata == kind;
	endfunction

	assign accept   = in_ch.valid && in_ch.ready;
	assign rows_m1  = rows_used - DW'(1);
	assign cols_m1  = cols_used - DW'(1);
	assign scan_last = ({1'b0, scan_row_q} == rows_m1) && ({1'b0, scan_col_q} == cols_m1);
	assign scan_edge = (scan_row_q == '0) || ({1'b0, scan_row_q} == rows_m1)
		|| (scan_col_q == '0) || ({1'b0, scan_col_q} == cols_m1);
	assign passable = (mem_rdata != gmw_pkg::KIND_WALL);

	// neighbour in the direction under trial
	always_comb begin
		logic ok;
		try_d = gmw_pkg::try_dir(heading_q, try_q);
		nr = {1'b0, pos_row_q};
		nc = {1'b0, pos_col_q};
		ok = 1'b1;
		case (try_d)
			gmw_pkg::DIR_N: begin
				ok = (pos_row_q != '0);
				nr = {1'b0, pos_row_q} - DW'(1);
			end
			gmw_pkg::DIR_E: nc = {1'b0, pos_col_q} + DW'(1);
			gmw_pkg::DIR_S: nr = {1'b0, pos_row_q} + DW'(1);
			default: begin
				ok = (pos_col_q != '0);
				nc = {1'b0, pos_col_q} - DW'(1);
			end
		endcase
		inb = ok && (nr < rows_used) && (nc < cols_used);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gmw_pkg::S_IDLE: begin
				if (accept) begin
					if (in_ch.mode == gmw_pkg::MODE_START) begin
						state_d = gmw_pkg::S_SCAN;
					end else if (in_ch.mode == gmw_pkg::MODE_STEP && walking_q) begin
						state_d = gmw_pkg::S_STEP_TRY;
					end else begin
						state_d = gmw_pkg::S_EMIT;
					end
				end
			end
			gmw_pkg::S_SCAN: begin
				if (scan_last) begin
					state_d = gmw_pkg::S_SCAN_END;
				end
			end
			gmw_pkg::S_SCAN_END:  state_d = gmw_pkg::S_SCAN_DONE;
			gmw_pkg::S_SCAN_DONE: state_d = gmw_pkg::S_EMIT;
			gmw_pkg::S_STEP_TRY: begin
				if (inb) begin
					state_d = gmw_pkg::S_STEP_CHK;
				end else if (try_q == gmw_pkg::LAST_TRY) begin
					state_d = gmw_pkg::S_EMIT;
				end
			end
			gmw_pkg::S_STEP_CHK: begin
				if (passable || try_q == gmw_pkg::LAST_TRY) begin
					state_d = gmw_pkg::S_EMIT;
				end else begin
					state_d = gmw_pkg::S_STEP_TRY;
				end
			end
			gmw_pkg::S_EMIT: begin
				if (res_ready) begin
					state_d = gmw_pkg::S_IDLE;
				end
			end
			default: state_d = gmw_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ch.ready   = 1'b0;
		res_valid     = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.re    = 1'b0;
		mem_req.addr  = {in_ch.cell_row, in_ch.cell_col};
		mem_req.wdata = in_ch.cell_kind;
		case (state_q)
			gmw_pkg::S_IDLE: begin
				in_ch.ready = 1'b1;
				mem_req.we  = in_ch.valid && (in_ch.mode == gmw_pkg::MODE_WRITE);
			end
			gmw_pkg::S_SCAN: begin
				mem_req.re   = 1'b1;
				mem_req.addr = {scan_row_q, scan_col_q};
			end
			gmw_pkg::S_STEP_TRY: begin
				mem_req.re   = inb;
				mem_req.addr = {nr[RW-1:0], nc[CW-1:0]};
			end
			gmw_pkg::S_EMIT: res_valid = 1'b1;
			default: begin
			end
		endcase
	end

	assign res.status = status_q;
	assign res.row    = pos_row_q;
	assign res.col    = pos_col_q;
	assign res.dir    = heading_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gmw_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// walker and scan datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_row_q    <= '0;
			pos_col_q    <= '0;
			heading_q    <= gmw_pkg::DIR_E;
			origin_row_q <= '0;
			origin_col_q <= '0;
			goal_row_q   <= '0;
			goal_col_q   <= '0;
			walking_q    <= 1'b0;
			status_q     <= gmw_pkg::ST_WRITTEN;
			valid_s1     <= 1'b0;
			scan_row_q   <= '0;
			scan_col_q   <= '0;
			bad_q        <= 1'b0;
			nstart_q     <= '0;
			nexit_q      <= '0;
			sr_q         <= '0;
			sc_q         <= '0;
			er_q         <= '0;
			ec_q         <= '0;
			try_q        <= '0;
		end else begin
			valid_s1 <= (state_q == gmw_pkg::S_SCAN);
			// checks on the cell read in the previous cycle
			if (valid_s1) begin
				if (mem_mem_kind_is(gmw_pkg::KIND_START)) begin
					if (nstart_q != 2'd2) begin
						nstart_q <= nstart_q + 2'd1;
					end
					sr_q <= row_s1;
					sc_q <= col_s1;
				end
				if (mem_mem_kind_is(gmw_pkg::KIND_EXIT)) begin
					if (nexit_q != 2'd2) begin
						nexit_q <= nexit_q + 2'd1;
					end
					er_q <= row_s1;
					ec_q <= col_s1;
				end
				if (edge_s1 && mem_mem_kind_is(gmw_pkg::KIND_OPEN)) begin
					bad_q <= 1'b1;
				end
			end
			case (state_q)
				gmw_pkg::S_IDLE: begin
					if (accept) begin
						scan_row_q <= '0;
						scan_col_q <= '0;
						bad_q      <= 1'b0;
						nstart_q   <= '0;
						nexit_q    <= '0;
						try_q      <= '0;
						if (in_ch.mode == gmw_pkg::MODE_WRITE) begin
							status_q <= gmw_pkg::ST_WRITTEN;
						end else begin
							status_q <= gmw_pkg::ST_INACTIVE;
						end
					end
				end
				gmw_pkg::S_SCAN: begin
					if ({1'b0, scan_col_q} == cols_m1) begin
						scan_col_q <= '0;
						scan_row_q <= scan_row_q + RW'(1);
					end else begin
						scan_col_q <= scan_col_q + CW'(1);
					end
				end
				gmw_pkg::S_SCAN_DONE: begin
					if (bad_q) begin
						walking_q <= 1'b0;
						status_q  <= gmw_pkg::ST_BAD_EDGE;
					end else if (nstart_q != 2'd1 || nexit_q != 2'd1) begin
						walking_q <= 1'b0;
						status_q  <= gmw_pkg::ST_BAD_CNT;
					end else begin
						status_q     <= gmw_pkg::ST_STARTED;
						walking_q    <= 1'b1;
						origin_row_q <= sr_q;
						origin_col_q <= sc_q;
						goal_row_q   <= er_q;
						goal_col_q   <= ec_q;
						pos_row_q    <= sr_q;
						pos_col_q    <= sc_q;
						if ({1'b0, sr_q} == rows_m1) begin
							heading_q <= gmw_pkg::DIR_N;
						end else if (sr_q == '0) begin
							heading_q <= gmw_pkg::DIR_S;
						end else if (sc_q == '0) begin
							heading_q <= gmw_pkg::DIR_E;
						end else if ({1'b0, sc_q} == cols_m1) begin
							heading_q <= gmw_pkg::DIR_W;
						end else begin
							heading_q <= gmw_pkg::DIR_E;
						end
					end
				end
				gmw_pkg::S_STEP_TRY: begin
					if (!inb) begin
						if (try_q == gmw_pkg::LAST_TRY) begin
							walking_q <= 1'b0;
							status_q  <= gmw_pkg::ST_BLOCKED;
						end else begin
							try_q <= try_q + 2'd1;
						end
					end
				end
				gmw_pkg::S_STEP_CHK: begin
					if (passable) begin
						heading_q <= cand_dir_s1;
						pos_row_q <= cand_row_s1;
						pos_col_q <= cand_col_s1;
						if (cand_row_s1 == goal_row_q && cand_col_s1 == goal_col_q) begin
							walking_q <= 1'b0;
							status_q  <= gmw_pkg::ST_EXIT;
						end else if (cand_row_s1 == origin_row_q
								&& cand_col_s1 == origin_col_q) begin
							walking_q <= 1'b0;
							status_q  <= gmw_pkg::ST_BACK;
						end else begin
							status_q <= gmw_pkg::ST_MOVED;
						end
					end else if (try_q == gmw_pkg::LAST_TRY) begin
						walking_q <= 1'b0;
						status_q  <= gmw_pkg::ST_BLOCKED;
					end else begin
						try_q <= try_q + 2'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// read-side stage registers, no reset needed
	always_ff @(posedge clk) begin
		row_s1      <= scan_row_q;
		col_s1      <= scan_col_q;
		edge_s1     <= scan_edge;
		cand_row_s1 <= nr[RW-1:0];
		cand_col_s1 <= nc[CW-1:0];
		cand_dir_s1 <= try_d;
	end

endmodule

`default_nettype wire

// ----- rtl/grid_maze_wall_follower.sv -----
// grid maze wall follower: write cells, start walk with a full grid scan, step by right hand
// a walking step reads up to four neighbours on the single grid memory port; start reads
// rows*cols cells, one cell read per cycle; one item in flight, next item taken once
// the result is in the output register; reset: walker at row 0 col 0 facing east, not
// walking, rows and cols 64; grid cells are undefined until written and get no clearing pass
`default_nettype none

module grid_maze_wall_follower (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	gmw_in_if.sink                         in_ch,
	gmw_out_if.source                      out_ch,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [gmw_pkg::DIM_W-1:0] cfg_data
);

	localparam int DW = gmw_pkg::DIM_W;

	logic [DW-1:0]     grid_rows_q, grid_cols_q;
	logic [DW-1:0]     rows_used, cols_used;
	gmw_pkg::mem_req_t mem_req;
	logic [1:0]        mem_rdata;
	logic              res_valid, res_ready;
	gmw_pkg::result_t  res, out_q;
	logic              out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= gmw_pkg::MAX_ROWS_DIM;
			grid_cols_q <= gmw_pkg::MAX_COLS_DIM;
		end else if (cfg_we) begin
			if (cfg_index == gmw_pkg::REG_ROWS) begin
				grid_rows_q <= cfg_data;
			end else begin
				grid_cols_q <= cfg_data;
			end
		end
	end

	assign rows_used = gmw_pkg::clamp_dim(grid_rows_q, gmw_pkg::MAX_ROWS_DIM);
	assign cols_used = gmw_pkg::clamp_dim(grid_cols_q, gmw_pkg::MAX_COLS_DIM);

	gmw_grid_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	gmw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.rows_used (rows_used),
		.cols_used (cols_used),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register
	assign res_ready = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.status     = out_q.status;
	assign out_ch.walker_row = out_q.row;
	assign out_ch.walker_col = out_q.col;
	assign out_ch.walker_dir = out_q.dir;

endmodule

`default_nettype wire

// ----- dv/gmw_walk_pkg.sv -----
// behavioral tracker for the grid maze wall follower: grid, walker and expected result queue
// depends on gmw_pkg for codes, widths and the result struct
`timescale 1ns / 100ps

package gmw_walk_pkg;

	import gmw_pkg::*;

	// the one mode code the block does not use
	localparam logic [1:0] MODE_SPARE = 2'd3;

	class maze_walk_tracker;
		logic [1:0] cells [MAX_ROWS][MAX_COLS];
		logic [DIM_W-1:0] rows_reg, cols_reg;
		logic [ROW_W-1:0] at_row, home_row, goal_row;
		logic [COL_W-1:0] at_col, home_col, goal_col;
		logic [1:0] facing;
		bit walking;
		result_t pending_reports[$];
		int mismatches;

		function new();
			foreach (cells[r, c]) cells[r][c] = KIND_OPEN;
			rows_reg = MAX_ROWS_DIM;
			cols_reg = MAX_COLS_DIM;
			at_row = '0;
			at_col = '0;
			home_row = '0;
			home_col = '0;
			goal_row = '0;
			goal_col = '0;
			facing = DIR_E;
			walking = 1'b0;
			mismatches = 0;
		endfunction

		function int rows_in_use();
			if (rows_reg == '0) return 1;
			if (rows_reg > MAX_ROWS_DIM) return MAX_ROWS;
			return int'(rows_reg);
		endfunction

		function int cols_in_use();
			if (cols_reg == '0) return 1;
			if (cols_reg > MAX_COLS_DIM) return MAX_COLS;
			return int'(cols_reg);
		endfunction

		function void write_reg(logic idx, logic [DIM_W-1:0] v);
			if (idx == REG_ROWS) begin
				rows_reg = v;
			end else begin
				cols_reg = v;
			end
		endfunction

		// cell next to the walker in heading d, if it lies in the area in use
		function bit neighbour_of(logic [1:0] d, output int nr, output int nc);
			int r, c;
			r = at_row;
			c = at_col;
			nr = 0;
			nc = 0;
			case (d)
				DIR_N: begin
					if (r == 0) return 1'b0;
					r--;
				end
				DIR_E: c++;
				DIR_S: r++;
				default: begin
					if (c == 0) return 1'b0;
					c--;
				end
			endcase
			if (r >= rows_in_use() || c >= cols_in_use()) return 1'b0;
			nr = r;
			nc = c;
			return 1'b1;
		endfunction

		function logic [3:0] scan_and_start();
			int rows, cols, n_start, n_exit, sr, sc, er, ec;
			bit bad_edge;
			rows = rows_in_use();
			cols = cols_in_use();
			n_start = 0;
			n_exit = 0;
			sr = 0;
			sc = 0;
			er = 0;
			ec = 0;
			bad_edge = 1'b0;
			for (int r = 0; r < rows; r++) begin
				for (int c = 0; c < cols; c++) begin
					if (cells[r][c] == KIND_START) begin
						n_start++;
						sr = r;
						sc = c;
					end
					if (cells[r][c] == KIND_EXIT) begin
						n_exit++;
						er = r;
						ec = c;
					end
					if ((r == 0 || r == rows - 1 || c == 0 || c == cols - 1) &&
							cells[r][c] == KIND_OPEN) begin
						bad_edge = 1'b1;
					end
				end
			end
			walking = 1'b0;
			if (bad_edge) return ST_BAD_EDGE;
			if (n_start != 1 || n_exit != 1) return ST_BAD_CNT;
			home_row = ROW_W'(sr);
			home_col = COL_W'(sc);
			goal_row = ROW_W'(er);
			goal_col = COL_W'(ec);
			at_row = ROW_W'(sr);
			at_col = COL_W'(sc);
			// face inward, row rules take priority over column rules
			if (sr == rows - 1) begin
				facing = DIR_N;
			end else if (sr == 0) begin
				facing = DIR_S;
			end else if (sc == 0) begin
				facing = DIR_E;
			end else if (sc == cols - 1) begin
				facing = DIR_W;
			end else begin
				facing = DIR_E;
			end
			walking = 1'b1;
			return ST_STARTED;
		endfunction

		function logic [3:0] step_once();
			logic [1:0] turn [4];
			logic [1:0] d;
			int nr, nc;
			// right, ahead, left, back as offsets from the heading
			turn = '{2'd1, 2'd0, 2'd3, 2'd2};
			if (!walking) return ST_INACTIVE;
			for (int i = 0; i < 4; i++) begin
				d = facing + turn[i];
				if (neighbour_of(d, nr, nc) && cells[nr][nc] != KIND_WALL) begin
					facing = d;
					at_row = ROW_W'(nr);
					at_col = COL_W'(nc);
					if (at_row == goal_row && at_col == goal_col) begin
						walking = 1'b0;
						return ST_EXIT;
					end
					if (at_row == home_row && at_col == home_col) begin
						walking = 1'b0;
						return ST_BACK;
					end
					return ST_MOVED;
				end
			end
			walking = 1'b0;
			return ST_BLOCKED;
		endfunction

		function void predict_walk(logic [1:0] mode, logic [ROW_W-1:0] row,
				logic [COL_W-1:0] col, logic [1:0] kind);
			logic [3:0] status;
			case (mode)
				MODE_WRITE: begin
					cells[row][col] = kind;
					status = ST_WRITTEN;
				end
				MODE_START: status = scan_and_start();
				MODE_STEP: status = step_once();
				default: status = ST_INACTIVE;
			endcase
			pending_reports.push_back('{status: status, row: at_row, col: at_col, dir: facing});
		endfunction

		function void check_report(result_t got);
			result_t want;
			if (pending_reports.size() == 0) begin
				$error("result with no item pending: status %0d", got.status);
				mismatches++;
				return;
			end
			want = pending_reports.pop_front();
			if (got.status !== want.status) begin
				$error("status mismatch: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
			if (got.row !== want.row) begin
				$error("walker_row mismatch: expected %0d, got %0d", want.row, got.row);
				mismatches++;
			end
			if (got.col !== want.col) begin
				$error("walker_col mismatch: expected %0d, got %0d", want.col, got.col);
				mismatches++;
			end
			if (got.dir !== want.dir) begin
				$error("walker_dir mismatch: expected %0d, got %0d", want.dir, got.dir);
				mismatches++;
			end
		endfunction
	endclass

endpackage

// ----- dv/grid_maze_wall_follower_test.sv -----
// top-level test for grid_maze_wall_follower: directed mazes, then random mazes and noise
// depends on gmw_pkg, the gmw_in_if/gmw_out_if interfaces and gmw_walk_pkg
`timescale 1ns / 100ps

module grid_maze_wall_follower_test;

	import gmw_pkg::*;
	import gmw_walk_pkg::*;

	localparam int LIMIT_CYCLES = 600000;
	localparam int ITEM_TARGET  = 850;
	localparam int STEP_CAP     = 90;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [DIM_W-1:0] cfg_data;

	gmw_in_if in_ch ();
	gmw_out_if out_ch ();

	maze_walk_tracker tracker = new();
	bit cell_written [MAX_ROWS][MAX_COLS];
	logic [1:0] maze_plan [MAX_ROWS][MAX_COLS];
	bit steady;
	int items_sent;
	int cycles;

	grid_maze_wall_follower uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	// result side: random stalls, check every accepted item
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (out_ch.valid !== 1'b1);
			tracker.check_report('{status: out_ch.status, row: out_ch.walker_row,
				col: out_ch.walker_col, dir: out_ch.walker_dir});
			@(negedge clk);
		end
	end

	// returns at the accepting edge; valid stays high for a back-to-back item
	task automatic send_item(logic [1:0] mode, logic [ROW_W-1:0] row,
			logic [COL_W-1:0] col, logic [1:0] kind);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= mode;
		in_ch.cell_row <= row;
		in_ch.cell_col <= col;
		in_ch.cell_kind <= kind;
		if (mode == MODE_WRITE) cell_written[row][col] = 1'b1;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		tracker.predict_walk(mode, row, col, kind);
		items_sent++;
	endtask

	// non-write item with a junk payload
	task automatic send_cmd(logic [1:0] mode);
		send_item(mode, ROW_W'($urandom_range(0, MAX_ROWS - 1)),
			COL_W'($urandom_range(0, MAX_COLS - 1)), 2'($urandom_range(0, 3)));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (tracker.pending_reports.size() != 0) @(negedge clk);
	endtask

	task automatic set_dims(logic [DIM_W-1:0] rv, logic [DIM_W-1:0] cv);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= REG_ROWS;
		cfg_data <= rv;
		tracker.write_reg(REG_ROWS, rv);
		@(negedge clk);
		cfg_index <= REG_COLS;
		cfg_data <= cv;
		tracker.write_reg(REG_COLS, cv);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// the block must never read a cell that was not written
	task automatic fill_area();
		for (int r = 0; r < tracker.rows_in_use(); r++) begin
			for (int c = 0; c < tracker.cols_in_use(); c++) begin
				if (!cell_written[r][c]) send_item(MODE_WRITE, ROW_W'(r), COL_W'(c), KIND_WALL);
			end
		end
	endtask

	function automatic void pick_cell(bit on_edge, int rows, int cols,
			output int r, output int c);
		r = $urandom_range(0, rows - 1);
		c = $urandom_range(0, cols - 1);
		if (on_edge) begin
			if ($urandom_range(0, 1) == 1) begin
				r = ($urandom_range(0, 1) == 1) ? 0 : rows - 1;
			end else begin
				c = ($urandom_range(0, 1) == 1) ? 0 : cols - 1;
			end
		end
	endfunction

	task automatic run_maze();
		int rows, cols, sr, sc, er, ec, fr, fc, budget, n, pick;
		rows = tracker.rows_in_use();
		cols = tracker.cols_in_use();
		for (int r = 0; r < rows; r++) begin
			for (int c = 0; c < cols; c++) begin
				if (r == 0 || r == rows - 1 || c == 0 || c == cols - 1 ||
						$urandom_range(0, 99) < 30) begin
					maze_plan[r][c] = KIND_WALL;
				end else begin
					maze_plan[r][c] = KIND_OPEN;
				end
			end
		end
		pick_cell($urandom_range(0, 9) < 6, rows, cols, sr, sc);
		pick_cell($urandom_range(0, 9) < 7, rows, cols, er, ec);
		for (int i = 0; i < 8 && er == sr && ec == sc; i++) pick_cell(1'b0, rows, cols, er, ec);
		maze_plan[sr][sc] = KIND_START;
		maze_plan[er][ec] = KIND_EXIT;
		// walled-in start, to reach the blocked outcome
		if ($urandom_range(0, 9) == 0) begin
			if (sr > 0 && !(sr - 1 == er && sc == ec)) maze_plan[sr - 1][sc] = KIND_WALL;
			if (sr < rows - 1 && !(sr + 1 == er && sc == ec)) maze_plan[sr + 1][sc] = KIND_WALL;
			if (sc > 0 && !(sr == er && sc - 1 == ec)) maze_plan[sr][sc - 1] = KIND_WALL;
			if (sc < cols - 1 && !(sr == er && sc + 1 == ec)) maze_plan[sr][sc + 1] = KIND_WALL;
		end
		// broken mazes: open edge, extra start, extra exit, no exit, edge and count both
		case ($urandom_range(0, 9))
			0: begin
				pick_cell(1'b1, rows, cols, fr, fc);
				maze_plan[fr][fc] = KIND_OPEN;
			end
			1: begin
				pick_cell(1'b0, rows, cols, fr, fc);
				maze_plan[fr][fc] = KIND_START;
			end
			2: begin
				pick_cell(1'b0, rows, cols, fr, fc);
				maze_plan[fr][fc] = KIND_EXIT;
			end
			3: maze_plan[er][ec] = KIND_WALL;
			4: begin
				pick_cell(1'b1, rows, cols, fr, fc);
				maze_plan[fr][fc] = KIND_OPEN;
				pick_cell(1'b0, rows, cols, fr, fc);
				maze_plan[fr][fc] = KIND_START;
			end
			default: ;
		endcase
		for (int r = 0; r < rows; r++) begin
			for (int c = 0; c < cols; c++) begin
				if (!cell_written[r][c] || tracker.cells[r][c] != maze_plan[r][c] ||
						$urandom_range(0, 4) == 0) begin
					send_item(MODE_WRITE, ROW_W'(r), COL_W'(c), maze_plan[r][c]);
				end
			end
		end
		send_cmd(MODE_START);
		// bounds change under a live walker
		if (tracker.walking && $urandom_range(0, 7) == 0) begin
			set_dims(DIM_W'($urandom_range(2, 8)), DIM_W'($urandom_range(2, 8)));
			fill_area();
		end
		budget = 2 * rows * cols + 6;
		if (budget > STEP_CAP) budget = STEP_CAP;
		for (n = 0; n < budget && tracker.walking; n++) begin
			pick = $urandom_range(0, 11);
			if (pick == 0) begin
				send_item(MODE_WRITE, ROW_W'($urandom_range(0, MAX_ROWS - 1)),
					COL_W'($urandom_range(0, MAX_COLS - 1)), 2'($urandom_range(0, 3)));
			end else if (pick == 1) begin
				send_cmd(MODE_SPARE);
			end else if (pick == 2 && $urandom_range(0, 3) == 0) begin
				send_cmd(MODE_START);
			end else begin
				send_cmd(MODE_STEP);
			end
		end
		if ($urandom_range(0, 1) == 1) send_cmd(MODE_STEP);
	endtask

	initial begin
		logic [DIM_W-1:0] rv, cv;
		logic [1:0] kind;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ROWS;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_WRITE;
		in_ch.cell_row = '0;
		in_ch.cell_col = '0;
		in_ch.cell_kind = KIND_OPEN;
		steady = 1'b0;
		items_sent = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed: idle walker, spare mode, field extremes
		send_cmd(MODE_STEP);
		send_cmd(MODE_SPARE);
		send_item(MODE_WRITE, 6'd63, 6'd63, KIND_EXIT);
		send_item(MODE_WRITE, 6'd0, 6'd0, KIND_OPEN);
		// 3x3 maze: start on the last row, straight run to the exit on the first row
		set_dims(7'd3, 7'd3);
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				kind = KIND_WALL;
				if (r == 1 && c == 1) kind = KIND_OPEN;
				if (r == 0 && c == 1) kind = KIND_EXIT;
				if (r == 2 && c == 1) kind = KIND_START;
				send_item(MODE_WRITE, ROW_W'(r), COL_W'(c), kind);
			end
		end
		send_cmd(MODE_START);
		send_cmd(MODE_STEP);
		send_cmd(MODE_STEP);
		// open edge, then open edge with bad counts, then bad counts alone
		send_item(MODE_WRITE, 6'd1, 6'd0, KIND_OPEN);
		send_cmd(MODE_START);
		send_item(MODE_WRITE, 6'd0, 6'd1, KIND_START);
		send_cmd(MODE_START);
		send_item(MODE_WRITE, 6'd1, 6'd0, KIND_WALL);
		send_cmd(MODE_START);
		send_cmd(MODE_STEP);

		while (items_sent < ITEM_TARGET) begin
			steady = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0: begin
					rv = DIM_W'($urandom_range(0, 1));
					cv = DIM_W'($urandom_range(0, 8));
				end
				1: begin
					rv = DIM_W'($urandom_range(0, 8));
					cv = DIM_W'($urandom_range(0, 1));
				end
				2: begin
					rv = ($urandom_range(0, 1) == 1) ? MAX_ROWS_DIM :
						DIM_W'($urandom_range(65, 127));
					cv = DIM_W'($urandom_range(0, 2));
				end
				3: begin
					rv = DIM_W'($urandom_range(0, 2));
					cv = ($urandom_range(0, 1) == 1) ? MAX_COLS_DIM :
						DIM_W'($urandom_range(65, 127));
				end
				default: begin
					rv = DIM_W'($urandom_range(3, 8));
					cv = DIM_W'($urandom_range(3, 8));
				end
			endcase
			set_dims(rv, cv);
			fill_area();
			repeat ($urandom_range(1, 3)) run_maze();
		end

		steady = 1'b0;
		wait_idle();
		repeat (12) @(negedge clk);
		if (tracker.mismatches == 0 && tracker.pending_reports.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
